### hdl/image_region_slot_table_unit_assert.svh
// Assertion macros used by the checker file of the slot table unit.
`ifndef IMAGE_REGION_SLOT_TABLE_UNIT_ASSERT_SVH
`define IMAGE_REGION_SLOT_TABLE_UNIT_ASSERT_SVH

// Same-cycle implication, muted while reset is high.
`define IRST_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, muted while reset is high.
`define IRST_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that also holds across reset.
`define IRST_ASSERT_ALWAYS(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hdl/irst_pkg.sv
// -----------------------------------------------------------------------------
// irst_pkg
// Shared types and defaults for the image region slot table.
// -----------------------------------------------------------------------------
package irst_pkg;

   localparam int SLOT_COUNT_DEF  = 16;
   localparam int CELL_LIMIT_DEF  = 297;
   localparam int STAMP_WIDTH_DEF = 32;
   localparam int ID_WIDTH_DEF    = 32;
   localparam int PEND_W          = 7;

   typedef enum logic [1:0] {
      FUNC_DRAW = 2'd0,
      FUNC_GC   = 2'd1,
      FUNC_MODE = 2'd2,
      FUNC_NONE = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      KIND_DEL_IMAGE      = 3'd0,
      KIND_TRANSMIT       = 3'd1,
      KIND_DEL_PLACE      = 3'd2,
      KIND_PLACE_CLASSIC  = 3'd3,
      KIND_PLACE_VIRTUAL  = 3'd4,
      KIND_GRID           = 3'd5,
      KIND_WARN           = 3'd6
   } kind_type;

   typedef enum logic [3:0] {
      OP_IDLE,
      OP_LOAD,
      OP_SCAN_DRAW,
      OP_PICK,
      OP_READ,
      OP_PLAN,
      OP_EMIT_DRAW,
      OP_WRITE_BACK,
      OP_SCAN_MASK,
      OP_SELECT,
      OP_EMIT_MASK,
      OP_FINISH
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } cmd_type;

   typedef struct packed {
      logic     scan_last;
      logic     out_free;
      logic     emit_last;
      logic     pend_empty;
      logic     mask_empty;
      logic     mode_same;
      func_type func;
   } status_type;

endpackage

### hdl/irst_ctrl.sv
// -----------------------------------------------------------------------------
// irst_ctrl
// Sequencer for draw, frame collection and mode switch transactions.
// -----------------------------------------------------------------------------
module irst_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  irst_pkg::status_type status,
   output irst_pkg::cmd_type    cmd
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_DSCAN,
      S_DPICK,
      S_DREAD,
      S_DPLAN,
      S_DEMIT,
      S_DWB,
      S_MSCAN,
      S_MSEL,
      S_MEMIT
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      cmd.op   = irst_pkg::OP_IDLE;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.op = irst_pkg::OP_LOAD;
               case (status.func)
                  irst_pkg::FUNC_DRAW: state_in = S_DSCAN;
                  irst_pkg::FUNC_GC:   state_in = S_MSCAN;
                  irst_pkg::FUNC_MODE: state_in = status.mode_same ? S_IDLE : S_MSCAN;
                  default:             state_in = S_IDLE;
               endcase
            end
         end
         S_DSCAN: begin
            cmd.op = irst_pkg::OP_SCAN_DRAW;
            if (status.scan_last) state_in = S_DPICK;
         end
         S_DPICK: begin
            cmd.op   = irst_pkg::OP_PICK;
            state_in = S_DREAD;
         end
         S_DREAD: begin
            cmd.op   = irst_pkg::OP_READ;
            state_in = S_DPLAN;
         end
         S_DPLAN: begin
            cmd.op   = irst_pkg::OP_PLAN;
            state_in = S_DEMIT;
         end
         S_DEMIT: begin
            // skip straight to write back when the draw needs no command
            if (status.pend_empty) begin
               state_in = S_DWB;
            end else if (status.out_free) begin
               cmd.op = irst_pkg::OP_EMIT_DRAW;
               if (status.emit_last) state_in = S_DWB;
            end
         end
         S_DWB: begin
            cmd.op   = irst_pkg::OP_WRITE_BACK;
            state_in = S_IDLE;
         end
         S_MSCAN: begin
            cmd.op = irst_pkg::OP_SCAN_MASK;
            if (status.scan_last) state_in = S_MSEL;
         end
         S_MSEL: begin
            if (status.mask_empty) begin
               cmd.op   = irst_pkg::OP_FINISH;
               state_in = S_IDLE;
            end else begin
               cmd.op   = irst_pkg::OP_SELECT;
               state_in = S_MEMIT;
            end
         end
         S_MEMIT: begin
            if (status.out_free) begin
               cmd.op   = irst_pkg::OP_EMIT_MASK;
               state_in = S_MSEL;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign req_stall = (state_ff != S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### hdl/irst_dp.sv
// -----------------------------------------------------------------------------
// irst_dp
// Slot storage, scan logic and command register of the slot table.
// -----------------------------------------------------------------------------
module irst_dp #(
   parameter int SLOT_COUNT  = irst_pkg::SLOT_COUNT_DEF,
   parameter int CELL_LIMIT  = irst_pkg::CELL_LIMIT_DEF,
   parameter int STAMP_WIDTH = irst_pkg::STAMP_WIDTH_DEF,
   parameter int ID_WIDTH    = irst_pkg::ID_WIDTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  irst_pkg::cmd_type    cmd,
   output irst_pkg::status_type status,
   input  logic [1:0]           req_func,
   input  logic [15:0]          req_region_x,
   input  logic [15:0]          req_region_y,
   input  logic [15:0]          req_region_w,
   input  logic [15:0]          req_region_h,
   input  logic [63:0]          req_content_hash,
   input  logic                 req_exact_fit,
   input  logic                 req_new_mode,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [2:0]           rsp_kind,
   output logic [ID_WIDTH-1:0]  rsp_img_ref,
   output logic [ID_WIDTH-1:0]  rsp_plc_ref,
   output logic [15:0]          rsp_at_x,
   output logic [15:0]          rsp_at_y,
   output logic [15:0]          rsp_cols,
   output logic [15:0]          rsp_rows,
   output logic                 rsp_place_exact,
   output logic                 rsp_last
);

   localparam int IDX_W = $clog2(SLOT_COUNT);
   localparam logic [15:0] LIMIT = 16'(CELL_LIMIT);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);
   localparam int PW = irst_pkg::PEND_W;

   // slot storage
   logic [SLOT_COUNT-1:0]  valid_ff;
   logic [63:0]            key_mem    [SLOT_COUNT];
   logic [63:0]            hash_mem   [SLOT_COUNT];
   logic [STAMP_WIDTH-1:0] stamp_mem  [SLOT_COUNT];
   logic [ID_WIDTH-1:0]    img_mem    [SLOT_COUNT];
   logic [ID_WIDTH-1:0]    pid_mem    [SLOT_COUNT];
   logic [SLOT_COUNT-1:0]  placed_mem;
   logic [SLOT_COUNT-1:0]  fit_mem;

   // global state
   logic [STAMP_WIDTH-1:0] draw_clock_ff;
   logic [STAMP_WIDTH-1:0] frame_start_ff;
   logic [ID_WIDTH-1:0]    next_img_ff;
   logic [ID_WIDTH-1:0]    next_pid_ff;
   logic                   mode_ff;
   logic                   warned_ff;

   // latched transaction
   irst_pkg::func_type func_ff;
   logic [15:0]        x_ff, y_ff, w_ff, h_ff;
   logic [63:0]        key_ff;
   logic [63:0]        hash_ff;
   logic               fit_ff;
   logic               new_mode_ff;
   logic               clamped_ff;

   // scan and working registers
   logic [IDX_W-1:0]       ptr_ff;
   logic                   hit_found_ff, free_found_ff;
   logic [IDX_W-1:0]       hit_idx_ff, free_idx_ff, old_idx_ff;
   logic [STAMP_WIDTH-1:0] old_stamp_ff;
   logic                   miss_ff, evict_ff;
   logic [ID_WIDTH-1:0]    w_img_ff, w_pid_ff;
   logic [63:0]            w_hash_ff;
   logic                   w_placed_ff, w_fit_ff;
   logic [PW-1:0]          pend_ff;
   logic [SLOT_COUNT-1:0]  mask_ff;

   // command register
   logic                   rsp_valid_ff;
   logic [2:0]             rsp_kind_ff;
   logic [ID_WIDTH-1:0]    rsp_img_ff, rsp_pid_ff;
   logic [15:0]            rsp_x_ff, rsp_y_ff, rsp_cols_ff, rsp_rows_ff;
   logic                   rsp_exact_ff, rsp_last_ff;

   logic                   out_free;
   logic [15:0]            w_cl, h_cl;
   logic                   clamp_w, clamp_h;
   logic [63:0]            hash_fix;
   logic [IDX_W-1:0]       pick_idx;
   logic [IDX_W-1:0]       mask_low;
   logic [PW-1:0]          pend_rest;
   logic [2:0]             pend_low;
   logic                   tx, fit_chg, del_place, placed_after;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   assign clamp_w  = mode_ff && (req_region_w > LIMIT);
   assign clamp_h  = mode_ff && (req_region_h > LIMIT);
   assign w_cl     = clamp_w ? LIMIT : req_region_w;
   assign h_cl     = clamp_h ? LIMIT : req_region_h;
   assign hash_fix = (req_content_hash == 64'd0) ? 64'd1 : req_content_hash;

   assign pick_idx = hit_found_ff ? hit_idx_ff : (free_found_ff ? free_idx_ff : old_idx_ff);

   always_comb begin
      mask_low = '0;
      for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
         if (mask_ff[i]) mask_low = IDX_W'(i);
      end
   end

   always_comb begin
      pend_low = '0;
      for (int i = PW - 1; i >= 0; i--) begin
         if (pend_ff[i]) pend_low = 3'(i);
      end
   end

   assign pend_rest = pend_ff & (pend_ff - 1'b1);

   // draw plan from the working copy of the slot
   assign tx           = (hash_ff != w_hash_ff);
   assign fit_chg      = (w_fit_ff != fit_ff);
   assign del_place    = (tx || fit_chg) && w_placed_ff;
   assign placed_after = w_placed_ff && !del_place;

   assign status.scan_last  = (ptr_ff == LAST_IDX);
   assign status.out_free   = out_free;
   assign status.emit_last  = (pend_rest == '0);
   assign status.pend_empty = (pend_ff == '0);
   assign status.mask_empty = (mask_ff == '0);
   assign status.mode_same  = (req_new_mode == mode_ff);
   assign status.func       = irst_pkg::func_type'(req_func);

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff       <= '0;
         draw_clock_ff  <= '0;
         frame_start_ff <= '0;
         next_img_ff    <= ID_WIDTH'(1);
         next_pid_ff    <= ID_WIDTH'(1);
         mode_ff        <= 1'b0;
         warned_ff      <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (cmd.op == irst_pkg::OP_EMIT_DRAW || cmd.op == irst_pkg::OP_EMIT_MASK) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (cmd.op)
            irst_pkg::OP_READ: begin
               if (miss_ff && !evict_ff) begin
                  next_img_ff <= next_img_ff + 1'b1;
                  next_pid_ff <= next_pid_ff + 1'b1;
               end
            end
            irst_pkg::OP_PLAN: begin
               draw_clock_ff <= draw_clock_ff + 1'b1;
               warned_ff     <= warned_ff || clamped_ff;
            end
            irst_pkg::OP_WRITE_BACK: valid_ff[ptr_ff] <= 1'b1;
            irst_pkg::OP_EMIT_MASK: begin
               if (func_ff == irst_pkg::FUNC_GC) valid_ff[ptr_ff] <= 1'b0;
            end
            irst_pkg::OP_FINISH: begin
               if (func_ff == irst_pkg::FUNC_GC) begin
                  frame_start_ff <= draw_clock_ff;
               end else begin
                  mode_ff <= new_mode_ff;
               end
            end
            default: ;
         endcase
      end
   end

   // payload, scan state and slot storage
   always_ff @(posedge clock) begin
      case (cmd.op)
         irst_pkg::OP_LOAD: begin
            func_ff       <= irst_pkg::func_type'(req_func);
            x_ff          <= req_region_x;
            y_ff          <= req_region_y;
            w_ff          <= w_cl;
            h_ff          <= h_cl;
            key_ff        <= {req_region_x, req_region_y, w_cl, h_cl};
            hash_ff       <= hash_fix;
            fit_ff        <= req_exact_fit;
            new_mode_ff   <= req_new_mode;
            clamped_ff    <= clamp_w || clamp_h;
            ptr_ff        <= '0;
            hit_found_ff  <= 1'b0;
            free_found_ff <= 1'b0;
            mask_ff       <= '0;
         end
         irst_pkg::OP_SCAN_DRAW: begin
            if (valid_ff[ptr_ff] && key_mem[ptr_ff] == key_ff && !hit_found_ff) begin
               hit_found_ff <= 1'b1;
               hit_idx_ff   <= ptr_ff;
            end
            if (!valid_ff[ptr_ff] && !free_found_ff) begin
               free_found_ff <= 1'b1;
               free_idx_ff   <= ptr_ff;
            end
            // strict compare keeps the lowest slot on ties
            if (ptr_ff == '0 || stamp_mem[ptr_ff] < old_stamp_ff) begin
               old_stamp_ff <= stamp_mem[ptr_ff];
               old_idx_ff   <= ptr_ff;
            end
            ptr_ff <= ptr_ff + 1'b1;
         end
         irst_pkg::OP_PICK: begin
            ptr_ff   <= pick_idx;
            miss_ff  <= !hit_found_ff;
            evict_ff <= !hit_found_ff && !free_found_ff;
         end
         irst_pkg::OP_READ: begin
            if (miss_ff && !evict_ff) begin
               w_img_ff <= next_img_ff;
               w_pid_ff <= next_pid_ff;
            end else begin
               w_img_ff <= img_mem[ptr_ff];
               w_pid_ff <= pid_mem[ptr_ff];
            end
            w_hash_ff   <= miss_ff ? 64'd0 : hash_mem[ptr_ff];
            w_placed_ff <= miss_ff ? 1'b0 : placed_mem[ptr_ff];
            w_fit_ff    <= miss_ff ? 1'b0 : fit_mem[ptr_ff];
         end
         irst_pkg::OP_PLAN: begin
            pend_ff[irst_pkg::KIND_DEL_IMAGE]     <= evict_ff;
            pend_ff[irst_pkg::KIND_TRANSMIT]      <= tx;
            pend_ff[irst_pkg::KIND_DEL_PLACE]     <= !mode_ff && del_place;
            pend_ff[irst_pkg::KIND_PLACE_CLASSIC] <= !mode_ff && !placed_after;
            pend_ff[irst_pkg::KIND_PLACE_VIRTUAL] <= mode_ff && !w_placed_ff;
            pend_ff[irst_pkg::KIND_GRID]          <= mode_ff;
            pend_ff[irst_pkg::KIND_WARN]          <= clamped_ff && !warned_ff;
         end
         irst_pkg::OP_EMIT_DRAW: begin
            pend_ff      <= pend_rest;
            rsp_kind_ff  <= pend_low;
            rsp_last_ff  <= (pend_rest == '0);
            if (pend_low == irst_pkg::KIND_WARN) begin
               rsp_img_ff <= '0;
               rsp_pid_ff <= '0;
            end else begin
               rsp_img_ff <= w_img_ff;
               rsp_pid_ff <= w_pid_ff;
            end
            if (pend_low == irst_pkg::KIND_PLACE_CLASSIC
                || pend_low == irst_pkg::KIND_PLACE_VIRTUAL
                || pend_low == irst_pkg::KIND_GRID) begin
               rsp_x_ff    <= x_ff;
               rsp_y_ff    <= y_ff;
               rsp_cols_ff <= w_ff;
               rsp_rows_ff <= h_ff;
            end else begin
               rsp_x_ff    <= '0;
               rsp_y_ff    <= '0;
               rsp_cols_ff <= '0;
               rsp_rows_ff <= '0;
            end
            rsp_exact_ff <= (pend_low == irst_pkg::KIND_PLACE_CLASSIC) && fit_ff;
         end
         irst_pkg::OP_WRITE_BACK: begin
            key_mem[ptr_ff]    <= key_ff;
            hash_mem[ptr_ff]   <= hash_ff;
            stamp_mem[ptr_ff]  <= draw_clock_ff;
            img_mem[ptr_ff]    <= w_img_ff;
            pid_mem[ptr_ff]    <= w_pid_ff;
            placed_mem[ptr_ff] <= 1'b1;
            fit_mem[ptr_ff]    <= fit_ff;
         end
         irst_pkg::OP_SCAN_MASK: begin
            if (func_ff == irst_pkg::FUNC_GC) begin
               mask_ff[ptr_ff] <= valid_ff[ptr_ff] && (stamp_mem[ptr_ff] <= frame_start_ff);
            end else begin
               mask_ff[ptr_ff] <= valid_ff[ptr_ff] && placed_mem[ptr_ff] && !mode_ff;
               // force a fresh transmit and placement after the switch
               if (valid_ff[ptr_ff]) begin
                  placed_mem[ptr_ff] <= 1'b0;
                  hash_mem[ptr_ff]   <= 64'd0;
               end
            end
            ptr_ff <= ptr_ff + 1'b1;
         end
         irst_pkg::OP_SELECT: begin
            ptr_ff            <= mask_low;
            mask_ff[mask_low] <= 1'b0;
         end
         irst_pkg::OP_EMIT_MASK: begin
            rsp_kind_ff  <= irst_pkg::KIND_DEL_IMAGE;
            rsp_img_ff   <= img_mem[ptr_ff];
            rsp_pid_ff   <= pid_mem[ptr_ff];
            rsp_x_ff     <= '0;
            rsp_y_ff     <= '0;
            rsp_cols_ff  <= '0;
            rsp_rows_ff  <= '0;
            rsp_exact_ff <= 1'b0;
            rsp_last_ff  <= (mask_ff == '0);
         end
         default: ;
      endcase
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kind         = rsp_kind_ff;
   assign rsp_img_ref      = rsp_img_ff;
   assign rsp_plc_ref      = rsp_pid_ff;
   assign rsp_at_x         = rsp_x_ff;
   assign rsp_at_y         = rsp_y_ff;
   assign rsp_cols         = rsp_cols_ff;
   assign rsp_rows         = rsp_rows_ff;
   assign rsp_place_exact  = rsp_exact_ff;
   assign rsp_last         = rsp_last_ff;

endmodule

### hdl/image_region_slot_table_unit.sv
// -----------------------------------------------------------------------------
// image_region_slot_table_unit
// Region slot table with LRU eviction, frame collection and mode switch.
// -----------------------------------------------------------------------------
// One transaction is taken at a time. A draw, frame collection and a mode
// switch to another mode first walk all SLOT_COUNT slots through a single
// slot read port, one slot per cycle. A draw then picks, reads and plans
// the slot, emits 0 to 5 commands and writes the slot back. Frame
// collection and a mode switch then emit one delete command per marked
// slot. A mode switch to the current mode and an unknown function end at
// the load, with no scan. Output stalls hold the emit states; the command
// register lets a new transaction start while the last command still waits.
module image_region_slot_table_unit #(
   parameter int SLOT_COUNT  = irst_pkg::SLOT_COUNT_DEF,
   parameter int CELL_LIMIT  = irst_pkg::CELL_LIMIT_DEF,
   parameter int STAMP_WIDTH = irst_pkg::STAMP_WIDTH_DEF,
   parameter int ID_WIDTH    = irst_pkg::ID_WIDTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [1:0]          req_func,
   input  logic [15:0]         req_region_x,
   input  logic [15:0]         req_region_y,
   input  logic [15:0]         req_region_w,
   input  logic [15:0]         req_region_h,
   input  logic [63:0]         req_content_hash,
   input  logic                req_exact_fit,
   input  logic                req_new_mode,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [2:0]          rsp_kind,
   output logic [ID_WIDTH-1:0] rsp_img_ref,
   output logic [ID_WIDTH-1:0] rsp_plc_ref,
   output logic [15:0]         rsp_at_x,
   output logic [15:0]         rsp_at_y,
   output logic [15:0]         rsp_cols,
   output logic [15:0]         rsp_rows,
   output logic                rsp_place_exact,
   output logic                rsp_last
);

   irst_pkg::cmd_type    cmd;
   irst_pkg::status_type status;

   irst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   irst_dp #(
      .SLOT_COUNT  (SLOT_COUNT),
      .CELL_LIMIT  (CELL_LIMIT),
      .STAMP_WIDTH (STAMP_WIDTH),
      .ID_WIDTH    (ID_WIDTH)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_func         (req_func),
      .req_region_x     (req_region_x),
      .req_region_y     (req_region_y),
      .req_region_w     (req_region_w),
      .req_region_h     (req_region_h),
      .req_content_hash (req_content_hash),
      .req_exact_fit    (req_exact_fit),
      .req_new_mode     (req_new_mode),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_img_ref      (rsp_img_ref),
      .rsp_plc_ref      (rsp_plc_ref),
      .rsp_at_x         (rsp_at_x),
      .rsp_at_y         (rsp_at_y),
      .rsp_cols         (rsp_cols),
      .rsp_rows         (rsp_rows),
      .rsp_place_exact  (rsp_place_exact),
      .rsp_last         (rsp_last)
   );

endmodule

### hdl/irst_checker.sv
// -----------------------------------------------------------------------------
// irst_checker
// Port-level checks of the slot table unit, bound to the top level.
// -----------------------------------------------------------------------------
`include "image_region_slot_table_unit_assert.svh"

module irst_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [2:0]  rsp_kind,
   input logic [31:0] rsp_img_ref,
   input logic [31:0] rsp_plc_ref,
   input logic [15:0] rsp_at_x,
   input logic [15:0] rsp_cols,
   input logic        rsp_place_exact
);

   `IRST_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_kind) && $stable(rsp_img_ref), "stalled command changed")

   `IRST_ASSERT_ALWAYS(a_reset_idle, clock, reset, !rsp_valid, "command shown right after reset")

   `IRST_ASSERT_NOW(a_warn_ids, clock, reset, rsp_valid && rsp_kind == irst_pkg::KIND_WARN, rsp_img_ref == 32'd0 && rsp_plc_ref == 32'd0, "clamp warning carries ids")

   `IRST_ASSERT_NOW(a_delete_geom, clock, reset, rsp_valid && (rsp_kind == irst_pkg::KIND_DEL_IMAGE || rsp_kind == irst_pkg::KIND_TRANSMIT || rsp_kind == irst_pkg::KIND_DEL_PLACE), rsp_at_x == 16'd0 && rsp_cols == 16'd0 && !rsp_place_exact, "non-place command carries geometry")

endmodule

bind image_region_slot_table_unit irst_checker u_irst_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_kind         (rsp_kind),
   .rsp_img_ref      (rsp_img_ref),
   .rsp_plc_ref      (rsp_plc_ref),
   .rsp_at_x         (rsp_at_x),
   .rsp_cols         (rsp_cols),
   .rsp_place_exact  (rsp_place_exact)
);
